### design/cpd_pkg.sv
package cpd_pkg;

  localparam int unsigned LatZones = 15;
  localparam int unsigned ZoneEven = 4 * LatZones;
  localparam int unsigned ZoneOdd  = 4 * LatZones - 1;
  localparam int unsigned NlRows   = 58;
  localparam logic [4:0]  DfPosition = 5'h11;
  localparam logic [4:0]  TcLow  = 5'd9;
  localparam logic [4:0]  TcHigh = 5'd18;
  localparam int unsigned DivWidth = 40;
  localparam logic [31:0] Deg270Bam = 32'hC000_0000;
  localparam logic [27:0] Deg8Scale = 28'd140625000;

  typedef enum logic [1:0] {
    KIND_STORED   = 2'd0,
    KIND_POSITION = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_OTHER    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [23:0] addr;
    logic        flag;
    logic [16:0] lat;
    logic [16:0] lon;
  } record_t;

  typedef struct packed {
    logic [DivWidth-1:0] dividend;
    logic [6:0]          divisor;
    logic                start;
  } div_req_t;

  typedef struct packed {
    logic [DivWidth-1:0] quotient;
    logic                done;
  } div_rsp_t;

  // zone thresholds in 1e-8 degree
  function automatic logic [35:0] nl_limit(input logic [5:0] k);
    logic [35:0] v;
    unique case (k)
      6'd0:  v = 36'd1047047130;
      6'd1:  v = 36'd1482817437;
      6'd2:  v = 36'd1818626357;
      6'd3:  v = 36'd2102939493;
      6'd4:  v = 36'd2354504487;
      6'd5:  v = 36'd2582924707;
      6'd6:  v = 36'd2793898710;
      6'd7:  v = 36'd2991135686;
      6'd8:  v = 36'd3177209708;
      6'd9:  v = 36'd3353993436;
      6'd10: v = 36'd3522899598;
      6'd11: v = 36'd3685025108;
      6'd12: v = 36'd3841241892;
      6'd13: v = 36'd3992256684;
      6'd14: v = 36'd4138651832;
      6'd15: v = 36'd4280914012;
      6'd16: v = 36'd4419454951;
      6'd17: v = 36'd4554626723;
      6'd18: v = 36'd4686733252;
      6'd19: v = 36'd4816039128;
      6'd20: v = 36'd4942776439;
      6'd21: v = 36'd5067150166;
      6'd22: v = 36'd5189342469;
      6'd23: v = 36'd5309516153;
      6'd24: v = 36'd5427817472;
      6'd25: v = 36'd5544378444;
      6'd26: v = 36'd5659318756;
      6'd27: v = 36'd5772747354;
      6'd28: v = 36'd5884763776;
      6'd29: v = 36'd5995459277;
      6'd30: v = 36'd6104917774;
      6'd31: v = 36'd6213216659;
      6'd32: v = 36'd6320427479;
      6'd33: v = 36'd6426616523;
      6'd34: v = 36'd6531845310;
      6'd35: v = 36'd6636171008;
      6'd36: v = 36'd6739646774;
      6'd37: v = 36'd6842322022;
      6'd38: v = 36'd6944242631;
      6'd39: v = 36'd7045451075;
      6'd40: v = 36'd7145986473;
      6'd41: v = 36'd7245884545;
      6'd42: v = 36'd7345177442;
      6'd43: v = 36'd7443893416;
      6'd44: v = 36'd7542056257;
      6'd45: v = 36'd7639684391;
      6'd46: v = 36'd7736789461;
      6'd47: v = 36'd7833374083;
      6'd48: v = 36'd7929428225;
      6'd49: v = 36'd8024923213;
      6'd50: v = 36'd8119801349;
      6'd51: v = 36'd8213956981;
      6'd52: v = 36'd8307199445;
      6'd53: v = 36'd8399173563;
      6'd54: v = 36'd8489166191;
      6'd55: v = 36'd8575541621;
      6'd56: v = 36'd8653536998;
      6'd57: v = 36'd8700000000;
      default: v = 36'd0;
    endcase
    return v;
  endfunction

endpackage

### design/cpd_ifs.sv
interface cpd_frame_if;
  logic        valid;
  logic        ready;
  logic [55:0] frame_head;
  logic [55:0] frame_tail;

  modport source (output valid, output frame_head, output frame_tail, input ready);
  modport sink (input valid, input frame_head, input frame_tail, output ready);
endinterface

interface cpd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [23:0]        aircraft_address;
  logic signed [31:0] latitude_angle;
  logic signed [31:0] longitude_angle;
  logic signed [16:0] altitude_feet;

  modport source (output valid, output kind, output aircraft_address,
                  output latitude_angle, output longitude_angle,
                  output altitude_feet, input ready);
  modport sink (input valid, input kind, input aircraft_address,
                input latitude_angle, input longitude_angle,
                input altitude_feet, output ready);
endinterface

### design/cpd_ram.sv
module cpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/cpd_div.sv
module cpd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpd_pkg::div_req_t  req_i,
  output cpd_pkg::div_rsp_t  rsp_o
);
  import cpd_pkg::*;

  logic [DivWidth-1:0] quo_q, quo_d;
  logic [6:0]          rem_q, rem_d;
  logic [6:0]          den_q, den_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [7:0]          shifted;
  logic                fits;

  assign shifted = {rem_q, quo_q[DivWidth-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = 6'(DivWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? 7'(shifted - {1'b0, den_q}) : shifted[6:0];
      quo_d = {quo_q[DivWidth-2:0], fits};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.quotient = quo_q;
  assign rsp_o.done     = done_q;

endmodule

### design/cpr_airborne_position_decoder.sv
// after reset the aircraft table is cleared, one entry per cycle, before the first transfer
// a frame that is not a position message goes from the transfer straight to the output state
// a stored frame is handled after a table scan that reads one entry per cycle
// a paired decode adds up to three divisions on the shared divider, two zone-table
// searches and a zone modulo by repeated add or subtract
// one frame at a time; a result waits in the output register while the next frame is taken
module cpr_airborne_position_decoder #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cpd_frame_if.sink           frame_i,
  cpd_result_if.source        result_o
);
  import cpd_pkg::*;

  localparam int unsigned AW = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_ENTRIES - 1);
  localparam int unsigned RW = $bits(record_t) + 1;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_SCAN   = 13'b0000000000100,
    S_SCANW  = 13'b0000000001000,
    S_DECIDE = 13'b0000000010000,
    S_JCALC  = 13'b0000000100000,
    S_DIVST  = 13'b0000001000000,
    S_DIVWT  = 13'b0000010000000,
    S_NLMUL  = 13'b0000100000000,
    S_NLSRCH = 13'b0001000000000,
    S_MCALC  = 13'b0010000000000,
    S_MMOD   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_LAT_EVEN = 2'd0,
    PH_LAT_ODD  = 2'd1,
    PH_LON      = 2'd2
  } phase_e;

  state_e  state_q, state_d;
  phase_e  phase_q, phase_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] evict_q, evict_d;
  logic          found_q, found_d;
  logic          free_q, free_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic          nlsel_q, nlsel_d;
  logic [5:0]    k_q, k_d;
  logic          ov_q, ov_d;

  record_t            cur_q, cur_d;
  record_t            past_q, past_d;
  logic signed [16:0] alt_q, alt_d;
  logic [1:0]         kind_q, kind_d;
  logic [5:0]         jme_q, jme_d;
  logic [5:0]         jmo_q, jmo_d;
  logic [31:0]        late_q, late_d;
  logic [31:0]        lato_q, lato_d;
  logic [31:0]        lon_q, lon_d;
  logic [35:0]        deg8_q, deg8_d;
  logic [5:0]         nle_q, nle_d;
  logic [5:0]         ni_q, ni_d;
  logic signed [8:0]  r_q, r_d;

  logic [1:0]         okind_q, okind_d;
  logic [23:0]        oaddr_q, oaddr_d;
  logic [31:0]        olat_q, olat_d;
  logic [31:0]        olon_q, olon_d;
  logic signed [16:0] oalt_q, oalt_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  record_t       ram_rec;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  logic [7:0]  b5, b6, b7, b8, b9, b10;
  logic [16:0] ye, yo, xe, xo;
  logic        even_latest;
  logic signed [25:0] jsum, msum;
  logic signed [8:0]  jval, mval;
  logic [31:0] mag;
  logic [59:0] prod;
  logic [5:0]  nl_found;
  logic [5:0]  nl_m1;
  logic        hit;

  cpd_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  cpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign b5  = frame_i.frame_head[15:8];
  assign b6  = frame_i.frame_head[7:0];
  assign b7  = frame_i.frame_tail[55:48];
  assign b8  = frame_i.frame_tail[47:40];
  assign b9  = frame_i.frame_tail[39:32];
  assign b10 = frame_i.frame_tail[31:24];

  assign ram_rec     = ram_rdata[RW-2:0];
  assign even_latest = ~cur_q.flag;
  assign ye = even_latest ? cur_q.lat : past_q.lat;
  assign yo = even_latest ? past_q.lat : cur_q.lat;
  assign xe = even_latest ? cur_q.lon : past_q.lon;
  assign xo = even_latest ? past_q.lon : cur_q.lon;

  assign jsum = 26'sd59 * $signed({9'b0, ye}) - 26'sd60 * $signed({9'b0, yo}) + 26'sd65536;
  assign jval = jsum[25:17];
  assign nl_m1 = nle_q - 6'd1;
  assign msum = $signed({9'b0, xe}) * $signed({20'b0, nl_m1})
              - $signed({9'b0, xo}) * $signed({20'b0, nle_q}) + 26'sd65536;
  assign mval = msum[25:17];

  assign mag  = (nlsel_q ? lato_q : late_q) >= Deg270Bam
              ? 32'(~(nlsel_q ? lato_q : late_q) + 32'd1)
              : (nlsel_q ? lato_q : late_q);
  assign prod = mag * Deg8Scale;
  assign hit  = (k_q == 6'(NlRows)) || (deg8_q < nl_limit(k_q));
  assign nl_found = 6'(59) - k_q;

  always_comb begin
    logic [11:0] alt12;
    logic [10:0] count;
    logic [17:0] feet;
    // q bit dropped from the altitude code
    alt12 = {b5, b6[7:4]};
    count = {alt12[11:5], alt12[3:0]};
    feet  = 18'(count) * 18'd25 - 18'd1000;

    state_d    = state_q;
    phase_d    = phase_q;
    idx_d      = idx_q;
    pidx_d     = idx_q;
    pend_d     = 1'b0;
    evict_d    = evict_q;
    found_d    = found_q;
    free_d     = free_q;
    slot_d     = slot_q;
    free_idx_d = free_idx_q;
    nlsel_d    = nlsel_q;
    k_d        = k_q;
    ov_d       = ov_q;
    cur_d      = cur_q;
    past_d     = past_q;
    alt_d      = alt_q;
    kind_d     = kind_q;
    jme_d      = jme_q;
    jmo_d      = jmo_q;
    late_d     = late_q;
    lato_d     = lato_q;
    lon_d      = lon_q;
    deg8_d     = deg8_q;
    nle_d      = nle_q;
    ni_d       = ni_q;
    r_d        = r_q;
    okind_d    = okind_q;
    oaddr_d    = oaddr_q;
    olat_d     = olat_q;
    olon_d     = olon_q;
    oalt_d     = oalt_q;

    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {1'b1, cur_q};
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    if (ov_q && result_o.ready) begin
      ov_d = 1'b0;
    end

    // table scan, data arrives in the cycle after the read
    if (pend_q) begin
      if (ram_rdata[RW-1]) begin
        if (!found_q && ram_rec.addr == cur_q.addr) begin
          found_d = 1'b1;
          slot_d  = pidx_q;
          past_d  = ram_rec;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_idx_d = pidx_q;
      end
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_d     = idx_q + AW'(1);
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (frame_i.valid) begin
          cur_d.addr = frame_i.frame_head[47:24];
          cur_d.flag = b6[2];
          cur_d.lat  = {b6[1:0], b7, b8[7:1]};
          cur_d.lon  = {b8[0], b9, b10};
          alt_d      = $signed(feet[16:0]);
          found_d    = 1'b0;
          free_d     = 1'b0;
          idx_d      = '0;
          if (frame_i.frame_head[55:51] != DfPosition ||
              frame_i.frame_head[23:19] < TcLow || frame_i.frame_head[23:19] > TcHigh) begin
            kind_d  = KIND_OTHER;
            late_d  = '0;
            lon_d   = '0;
            alt_d   = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_re = 1'b1;
        pend_d = 1'b1;
        idx_d  = idx_q + AW'(1);
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = S_SCANW;
        end
      end
      S_SCANW: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!found_q || past_q.flag == cur_q.flag) begin
          ram_we = 1'b1;
          if (found_q) begin
            ram_waddr = slot_q;
          end else if (free_q) begin
            ram_waddr = free_idx_q;
          end else begin
            ram_waddr = evict_q;
            evict_d   = (evict_q == LastIdx) ? '0 : evict_q + AW'(1);
          end
          kind_d  = KIND_STORED;
          late_d  = '0;
          lon_d   = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_JCALC;
        end
      end
      S_JCALC: begin
        jme_d = jval < 0 ? 6'(jval + 9'sd60) : jval[5:0];
        if (jval < -9'sd59) begin
          jmo_d = 6'(jval + 9'sd118);
        end else if (jval < 0) begin
          jmo_d = 6'(jval + 9'sd59);
        end else if (jval >= 9'sd59) begin
          jmo_d = 6'(jval - 9'sd59);
        end else begin
          jmo_d = jval[5:0];
        end
        phase_d = PH_LAT_EVEN;
        state_d = S_DIVST;
      end
      S_DIVST: begin
        div_req.start = 1'b1;
        unique case (phase_q)
          PH_LAT_EVEN: begin
            div_req.dividend = {1'b0, jme_q, ye, 9'b0, 7'(ZoneEven)};
            div_req.divisor  = 7'(2 * ZoneEven);
          end
          PH_LAT_ODD: begin
            div_req.dividend = {1'b0, jmo_q, yo, 9'b0, 7'(ZoneOdd)};
            div_req.divisor  = 7'(2 * ZoneOdd);
          end
          default: begin
            div_req.dividend = {1'b0, r_q[5:0], even_latest ? xe : xo, 9'b0, 1'b0, ni_q};
            div_req.divisor  = {ni_q, 1'b0};
          end
        endcase
        state_d = S_DIVWT;
      end
      S_DIVWT: begin
        if (div_rsp.done) begin
          unique case (phase_q)
            PH_LAT_EVEN: begin
              late_d  = div_rsp.quotient[31:0];
              phase_d = PH_LAT_ODD;
              state_d = S_DIVST;
            end
            PH_LAT_ODD: begin
              lato_d  = div_rsp.quotient[31:0];
              nlsel_d = 1'b0;
              state_d = S_NLMUL;
            end
            default: begin
              lon_d   = div_rsp.quotient[31:0];
              late_d  = even_latest ? late_q : lato_q;
              kind_d  = KIND_POSITION;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_NLMUL: begin
        deg8_d  = prod[59:24];
        k_d     = '0;
        state_d = S_NLSRCH;
      end
      S_NLSRCH: begin
        if (hit) begin
          if (!nlsel_q) begin
            nle_d   = nl_found;
            nlsel_d = 1'b1;
            state_d = S_NLMUL;
          end else begin
            if (nl_found != nle_q) begin
              kind_d  = KIND_MISMATCH;
              late_d  = '0;
              lon_d   = '0;
              state_d = S_OUT;
            end else begin
              state_d = S_MCALC;
            end
          end
        end else begin
          k_d = k_q + 6'd1;
        end
      end
      S_MCALC: begin
        r_d = mval;
        if (even_latest) begin
          ni_d = nle_q;
        end else begin
          ni_d = (nle_q > 6'd1) ? nl_m1 : 6'd1;
        end
        state_d = S_MMOD;
      end
      S_MMOD: begin
        if (r_q < 0) begin
          r_d = r_q + $signed({3'b0, ni_q});
        end else if (r_q >= $signed({3'b0, ni_q})) begin
          r_d = r_q - $signed({3'b0, ni_q});
        end else begin
          phase_d = PH_LON;
          state_d = S_DIVST;
        end
      end
      S_OUT: begin
        if (!ov_q || result_o.ready) begin
          ov_d    = 1'b1;
          okind_d = kind_q;
          oaddr_d = cur_q.addr;
          olat_d  = late_q;
          olon_d  = lon_q;
          oalt_d  = alt_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= PH_LAT_EVEN;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      evict_q <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      nlsel_q <= 1'b0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      evict_q <= evict_d;
      found_q <= found_d;
      free_q  <= free_d;
      nlsel_q <= nlsel_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    slot_q     <= slot_d;
    free_idx_q <= free_idx_d;
    cur_q      <= cur_d;
    past_q     <= past_d;
    alt_q      <= alt_d;
    kind_q     <= kind_d;
    jme_q      <= jme_d;
    jmo_q      <= jmo_d;
    late_q     <= late_d;
    lato_q     <= lato_d;
    lon_q      <= lon_d;
    deg8_q     <= deg8_d;
    nle_q      <= nle_d;
    ni_q       <= ni_d;
    r_q        <= r_d;
    okind_q    <= okind_d;
    oaddr_q    <= oaddr_d;
    olat_q     <= olat_d;
    olon_q     <= olon_d;
    oalt_q     <= oalt_d;
  end

  assign frame_i.ready             = (state_q == S_IDLE);
  assign result_o.valid            = ov_q;
  assign result_o.kind             = okind_q;
  assign result_o.aircraft_address = oaddr_q;
  assign result_o.latitude_angle   = $signed(olat_q);
  assign result_o.longitude_angle  = $signed(olon_q);
  assign result_o.altitude_feet    = oalt_q;

endmodule
